/* hw/rtl/one_shot_pad_sample_mixer_unit_assert.svh */
// ----------------------------------------------------------------------------
// one-shot pad sample mixer assertion macros
// shared concurrent assertion forms, same-cycle and next-cycle implication
// ----------------------------------------------------------------------------
`ifndef ONE_SHOT_PAD_SAMPLE_MIXER_UNIT_ASSERT_SVH
`define ONE_SHOT_PAD_SAMPLE_MIXER_UNIT_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define OSPSM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define OSPSM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/ospsm_pkg.sv */
// ----------------------------------------------------------------------------
// ospsm_pkg
// shared types, codes and helpers of the one-shot pad sample mixer
// ----------------------------------------------------------------------------
package ospsm_pkg;

  localparam int DEF_PADS       = 8;
  localparam int DEF_MAX_FRAMES = 4096;
  localparam int MASK_W         = 8;
  localparam logic [15:0] GAIN_UNITY = 16'h8000;
  localparam logic [1:0]  OC_RESET   = 2'd2;

  // request codes
  typedef enum logic [1:0] {
    REQ_WRITE = 2'd0,
    REQ_LOAD  = 2'd1,
    REQ_TRIG  = 2'd2,
    REQ_TICK  = 2'd3
  } req_e_t;

  // configuration register indexes
  localparam logic CFG_MASTER_VOLUME = 1'b0;
  localparam logic CFG_OUT_CHANNELS  = 1'b1;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [2:0]         pad;
    logic               channel;
    logic [11:0]        address;
    logic signed [15:0] sample_value;
    logic [12:0]        length;
    logic [1:0]         channel_count;
    logic [15:0]        velocity;
    logic signed [15:0] dry_left;
    logic signed [15:0] dry_right;
  } in_beat_t;

  typedef struct packed {
    logic signed [19:0] mix_left;
    logic signed [19:0] mix_right;
    logic               status;
    logic [7:0]         playing_mask;
    logic [7:0]         loaded_mask;
  } out_beat_t;

  // classified command handed from front to back
  typedef struct packed {
    req_e_t             op;
    logic [2:0]         pad;
    logic               pad_ok;
    logic               channel;
    logic [11:0]        address;
    logic               addr_ok;
    logic signed [15:0] sample;
    logic [12:0]        length;
    logic               stereo;
    logic [15:0]        velocity;
    logic signed [15:0] dry_left;
    logic signed [15:0] dry_right;
  } cmd_t;

  // q1.15 gain limited to unity
  function automatic logic [15:0] clamp_gain(input logic [15:0] v);
    return (v > GAIN_UNITY) ? GAIN_UNITY : v;
  endfunction

endpackage

/* hw/rtl/ospsm_in_if.sv */
// ----------------------------------------------------------------------------
// ospsm_in_if
// request channel: valid, ready and one input beat
// ----------------------------------------------------------------------------
interface ospsm_in_if;
  logic                valid;
  logic                ready;
  ospsm_pkg::in_beat_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* hw/rtl/ospsm_out_if.sv */
// ----------------------------------------------------------------------------
// ospsm_out_if
// result channel: valid, ready and one result beat
// ----------------------------------------------------------------------------
interface ospsm_out_if;
  logic                 valid;
  logic                 ready;
  ospsm_pkg::out_beat_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* hw/rtl/ospsm_cfg_if.sv */
// ----------------------------------------------------------------------------
// ospsm_cfg_if
// configuration write channel: register index and write data
// ----------------------------------------------------------------------------
interface ospsm_cfg_if;
  logic        valid;
  logic        ready;
  logic        index;
  logic [15:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

/* hw/rtl/ospsm_front.sv */
// ----------------------------------------------------------------------------
// ospsm_front
// accepts request beats, classifies them and queues them for the back end
// ----------------------------------------------------------------------------
module ospsm_front #(
  parameter int PADS       = ospsm_pkg::DEF_PADS,
  parameter int MAX_FRAMES = ospsm_pkg::DEF_MAX_FRAMES
) (
  input  logic              clk,
  input  logic              rst_n,
  ospsm_in_if.sink          in_ch,
  output ospsm_pkg::cmd_t   q_data,
  output logic              q_valid,
  input  logic              q_pop
);

  ospsm_pkg::cmd_t q_mem_r [2];
  logic            wr_ptr_r;
  logic            rd_ptr_r;
  logic [1:0]      cnt_r;
  ospsm_pkg::cmd_t cls;
  logic            push;

  // classify the incoming beat
  always_comb begin
    cls.op        = ospsm_pkg::req_e_t'(in_ch.data.req_type);
    cls.pad       = in_ch.data.pad;
    cls.pad_ok    = 32'(in_ch.data.pad) < PADS;
    cls.channel   = in_ch.data.channel;
    cls.address   = in_ch.data.address;
    cls.addr_ok   = 32'(in_ch.data.address) < MAX_FRAMES;
    cls.sample    = in_ch.data.sample_value;
    cls.length    = (32'(in_ch.data.length) > MAX_FRAMES) ? 13'(MAX_FRAMES)
                                                          : in_ch.data.length;
    cls.stereo    = in_ch.data.channel_count[1];
    cls.velocity  = ospsm_pkg::clamp_gain(in_ch.data.velocity);
    cls.dry_left  = in_ch.data.dry_left;
    cls.dry_right = in_ch.data.dry_right;
  end

  assign in_ch.ready = (cnt_r != 2'd2);
  assign push        = in_ch.valid && in_ch.ready;
  assign q_valid     = (cnt_r != 2'd0);
  assign q_data      = q_mem_r[rd_ptr_r];

  // two-entry queue
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        q_mem_r[wr_ptr_r] <= cls;
        wr_ptr_r          <= ~wr_ptr_r;
      end
      if (q_pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      cnt_r <= cnt_r + 2'(push) - 2'(q_pop);
    end
  end

endmodule

/* hw/rtl/ospsm_back.sv */
// ----------------------------------------------------------------------------
// ospsm_back
// executes queued commands: sample store, pad state, per-pad mix sequencer
// ----------------------------------------------------------------------------
`include "one_shot_pad_sample_mixer_unit_assert.svh"

module ospsm_back #(
  parameter int PADS       = ospsm_pkg::DEF_PADS,
  parameter int MAX_FRAMES = ospsm_pkg::DEF_MAX_FRAMES
) (
  input  logic            clk,
  input  logic            rst_n,
  input  ospsm_pkg::cmd_t q_data,
  input  logic            q_valid,
  output logic            q_pop,
  ospsm_out_if.source     out_ch,
  ospsm_cfg_if.sink       cfg_ch
);

  localparam int PIW   = (PADS > 1) ? $clog2(PADS) : 1;
  localparam int LW    = $clog2(MAX_FRAMES + 1);
  localparam int DEPTH = PADS * 2 * MAX_FRAMES;
  localparam int AW    = $clog2(DEPTH);

  typedef enum logic [2:0] {S_IDLE, S_P0, S_P1, S_P2, S_P3, S_FIN} state_t;

  state_t               state_r;
  logic [15:0]          mv_r;
  logic [1:0]           oc_r;
  logic [LW-1:0]        len_r   [PADS];
  logic                 stereo_r[PADS];
  logic                 loaded_r[PADS];
  logic                 playing_r[PADS];
  logic [LW-1:0]        pos_r   [PADS];
  logic [15:0]          vel_r   [PADS];
  logic [PIW-1:0]       q_r;
  logic                 status_r;
  logic signed [19:0]   acc_l_r;
  logic signed [19:0]   acc_r_r;
  logic [31:0]          g_r;
  logic                 hit_r;
  logic [LW-1:0]        rpos_r;
  logic                 rsel_r;
  logic signed [47:0]   prod_r;
  logic signed [15:0]   rdata_r;
  logic                 out_valid_r;
  ospsm_pkg::out_beat_t out_data_r;

  logic signed [15:0]   mem [DEPTH];
  logic [AW-1:0]        raddr;
  logic [AW-1:0]        waddr;
  logic                 we;
  logic                 stereo_out;
  logic                 out_free;
  logic [PIW-1:0]       pi;
  logic [LW:0]          pos_inc;
  logic signed [47:0]   prod_nxt;
  logic signed [47:0]   prod_sh;
  logic [7:0]           pl_mask;
  logic [7:0]           ld_mask;
  logic                 q_tick;
  logic                 trig_miss;

  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;
  assign stereo_out   = oc_r[1];
  assign out_free     = !out_valid_r || out_ch.ready;
  assign q_pop        = (state_r == S_IDLE) && q_valid;
  assign pi           = PIW'(q_data.pad);
  assign pos_inc      = {1'b0, pos_r[q_r]} + (LW+1)'(1);
  assign prod_nxt     = 48'(rdata_r) * 48'($signed({1'b0, g_r}));
  assign prod_sh      = prod_r >>> 30;
  assign q_tick       = (q_data.op == ospsm_pkg::REQ_TICK);
  assign trig_miss    = (q_data.op == ospsm_pkg::REQ_TRIG)
                        && !(q_data.pad_ok && loaded_r[pi]);

  // store addressing: row is pad and channel, then frame
  assign we    = q_pop && (q_data.op == ospsm_pkg::REQ_WRITE) && q_data.pad_ok
                 && q_data.addr_ok;
  assign waddr = AW'({PIW'(q_data.pad), q_data.channel}) * AW'(MAX_FRAMES)
                 + AW'(q_data.address);

  always_comb begin
    case (state_r)
      S_P1:    raddr = AW'({q_r, rsel_r}) * AW'(MAX_FRAMES) + AW'(rpos_r);
      default: raddr = AW'({q_r, 1'b0}) * AW'(MAX_FRAMES) + AW'(pos_r[q_r]);
    endcase
  end

  // sample store, one write and one registered read a cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= q_data.sample;
    end
    rdata_r <= mem[raddr];
  end

  // status masks
  always_comb begin
    pl_mask = '0;
    ld_mask = '0;
    for (int i = 0; i < ospsm_pkg::MASK_W && i < PADS; i++) begin
      pl_mask[i] = playing_r[i];
      ld_mask[i] = loaded_r[i];
    end
  end

  // control sequencer and pad state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      mv_r        <= ospsm_pkg::GAIN_UNITY;
      oc_r        <= ospsm_pkg::OC_RESET;
      q_r         <= '0;
      for (int i = 0; i < PADS; i++) begin
        len_r[i]     <= '0;
        stereo_r[i]  <= 1'b0;
        loaded_r[i]  <= 1'b0;
        playing_r[i] <= 1'b0;
        pos_r[i]     <= '0;
        vel_r[i]     <= '0;
      end
    end else begin
      // configuration writes
      if (cfg_ch.valid) begin
        case (cfg_ch.index)
          ospsm_pkg::CFG_MASTER_VOLUME: mv_r <= ospsm_pkg::clamp_gain(cfg_ch.data);
          ospsm_pkg::CFG_OUT_CHANNELS:  oc_r <= cfg_ch.data[1:0];
          default: ;
        endcase
      end
      // result register valid flag
      if ((state_r == S_FIN) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.valid && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            status_r <= trig_miss;
            acc_l_r  <= q_tick ? 20'(q_data.dry_left) : 20'sd0;
            acc_r_r  <= (q_tick && stereo_out) ? 20'(q_data.dry_right) : 20'sd0;
            q_r      <= '0;
            case (q_data.op)
              ospsm_pkg::REQ_LOAD: begin
                if (q_data.pad_ok) begin
                  len_r[pi]     <= LW'(q_data.length);
                  stereo_r[pi]  <= q_data.stereo;
                  loaded_r[pi]  <= 1'b1;
                  playing_r[pi] <= 1'b0;
                  pos_r[pi]     <= '0;
                end
              end
              ospsm_pkg::REQ_TRIG: begin
                if (!trig_miss) begin
                  pos_r[pi]     <= '0;
                  vel_r[pi]     <= q_data.velocity;
                  playing_r[pi] <= 1'b1;
                end
              end
              default: ;
            endcase
            state_r <= q_tick ? S_P0 : S_FIN;
          end
        end
        // left read issued, gain formed, position advanced
        S_P0: begin
          hit_r  <= playing_r[q_r] && (pos_r[q_r] < len_r[q_r]);
          g_r    <= 32'(vel_r[q_r]) * 32'(mv_r);
          rpos_r <= pos_r[q_r];
          rsel_r <= stereo_r[q_r];
          if (playing_r[q_r]) begin
            if (pos_inc >= {1'b0, len_r[q_r]}) begin
              playing_r[q_r] <= 1'b0;
              pos_r[q_r]     <= '0;
            end else begin
              pos_r[q_r] <= LW'(pos_inc);
            end
          end
          state_r <= S_P1;
        end
        // left word scaled, right read issued (left again for a mono pad)
        S_P1: begin
          prod_r  <= prod_nxt;
          state_r <= S_P2;
        end
        S_P2: begin
          if (hit_r) begin
            acc_l_r <= acc_l_r + prod_sh[19:0];
          end
          prod_r  <= prod_nxt;
          state_r <= S_P3;
        end
        S_P3: begin
          if (hit_r && stereo_out) begin
            acc_r_r <= acc_r_r + prod_sh[19:0];
          end
          if (q_r == PIW'(PADS - 1)) begin
            state_r <= S_FIN;
          end else begin
            q_r     <= q_r + PIW'(1);
            state_r <= S_P0;
          end
        end
        // hand the result to the output register
        S_FIN: begin
          if (out_free) begin
            out_data_r.mix_left     <= acc_l_r;
            out_data_r.mix_right    <= acc_r_r;
            out_data_r.status       <= status_r;
            out_data_r.playing_mask <= pl_mask;
            out_data_r.loaded_mask  <= ld_mask;
            state_r                 <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  `OSPSM_ASSERT_NOW(a_play_implies_loaded, clk, rst_n, 1'b1,
    (pl_mask & ~ld_mask) == 8'd0, "pad playing while not loaded")
  `OSPSM_ASSERT_NEXT(a_tick_starts_walk, clk, rst_n, q_pop && q_tick,
    state_r == S_P0, "tick did not start pad walk")
  `OSPSM_ASSERT_NEXT(a_fin_delivers, clk, rst_n, (state_r == S_FIN) && out_free,
    out_valid_r && (state_r == S_IDLE), "finished result not registered")

endmodule

/* hw/rtl/one_shot_pad_sample_mixer_unit.sv */
// ----------------------------------------------------------------------------
// one_shot_pad_sample_mixer_unit
// drum-pad one-shot sampler with per-frame mixing onto a dry input
// ----------------------------------------------------------------------------
// Requests enter a two-beat queue and run one at a time. Word writes, pad
// loads and triggers pass through the idle and finish states to the output
// register, waiting while it is full. A tick walks each pad through the
// sample store in four steps (left read and gain, left scale and right read,
// left add and right scale, right add). Each pad holds two channels of
// MAX_FRAMES words; reading a word never written gives an undefined value.
// Configuration writes are always ready and belong between requests.
module one_shot_pad_sample_mixer_unit #(
  parameter int PADS       = ospsm_pkg::DEF_PADS,
  parameter int MAX_FRAMES = ospsm_pkg::DEF_MAX_FRAMES
) (
  input  logic        clk,
  input  logic        rst_n,
  ospsm_in_if.sink    in_ch,
  ospsm_out_if.source out_ch,
  ospsm_cfg_if.sink   cfg_ch
);

  ospsm_pkg::cmd_t q_data;
  logic            q_valid;
  logic            q_pop;

  // request front end and queue
  ospsm_front #(.PADS(PADS), .MAX_FRAMES(MAX_FRAMES)) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .q_data  (q_data),
    .q_valid (q_valid),
    .q_pop   (q_pop)
  );

  // execution back end
  ospsm_back #(.PADS(PADS), .MAX_FRAMES(MAX_FRAMES)) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_data  (q_data),
    .q_valid (q_valid),
    .q_pop   (q_pop),
    .out_ch  (out_ch),
    .cfg_ch  (cfg_ch)
  );

endmodule
